// ===== hdl/pps_pkg.sv =====
`timescale 1ns / 1ps

package pps_pkg;

	localparam int CAPACITY      = 4096;
	localparam int PALETTE_DEPTH = 256;
	localparam int WORD_DEPTH    = 1024;

	localparam int ID_W    = 16;
	localparam int WORD_B  = 64;
	localparam int CAP_W   = $clog2(CAPACITY);
	localparam int PAL_W   = $clog2(PALETTE_DEPTH);
	localparam int WORD_W  = $clog2(WORD_DEPTH);
	localparam int PER_W   = 7;
	localparam int SHIFT_W = 7;
	localparam int ENT_W   = $clog2(WORD_DEPTH * WORD_B) + 1;
	localparam int CNT_W   = PAL_W + 1;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_NONE  = 2'd3;

	localparam logic [1:0] FORM_UNIFORM = 2'd0;
	localparam logic [1:0] FORM_INDEXED = 2'd1;
	localparam logic [1:0] FORM_DIRECT  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIRECT_W  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_W     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_W     = 3'd4;

	typedef struct packed {
		logic             start;
		logic [CAP_W-1:0] dividend;
		logic [PER_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [CAP_W-1:0] quot;
		logic [PER_W-1:0] rem;
	} div_rsp_t;

	// entries per 64-bit word for a given entry width
	function automatic logic [PER_W-1:0] per_of(input logic [4:0] w);
		logic [PER_W-1:0] p;
		case (w)
			5'd1:    p = 7'd64;
			5'd2:    p = 7'd32;
			5'd3:    p = 7'd21;
			5'd4:    p = 7'd16;
			5'd5:    p = 7'd12;
			5'd6:    p = 7'd10;
			5'd7:    p = 7'd9;
			5'd8:    p = 7'd8;
			5'd9:    p = 7'd7;
			5'd10:   p = 7'd6;
			5'd11:   p = 7'd5;
			5'd12:   p = 7'd5;
			5'd13:   p = 7'd4;
			5'd14:   p = 7'd4;
			5'd15:   p = 7'd4;
			5'd16:   p = 7'd4;
			default: p = 7'd64;
		endcase
		return p;
	endfunction

	function automatic logic [ID_W-1:0] mask_of(input logic [4:0] w);
		logic [ID_W-1:0] m;
		if (w >= 5'd16) m = '1;
		else m = ID_W'((17'd1 << w) - 17'd1);
		return m;
	endfunction

	function automatic logic [4:0] clamp_w(input logic [4:0] v, input logic [4:0] hi);
		logic [4:0] r;
		if (v == 5'd0) r = 5'd1;
		else if (v > hi) r = hi;
		else r = v;
		return r;
	endfunction

	// index bits for a palette of the given size, at least the minimum width
	function automatic logic [4:0] index_width_for(input logic [CNT_W:0] size,
		input logic [3:0] minw);
		logic [4:0] b;
		logic [4:0] mn;
		b = 5'd16;
		for (int k = 16; k >= 0; k--) begin
			if ((32'd1 << k) >= 32'(size)) b = 5'(k);
		end
		mn = clamp_w({1'b0, minw}, 5'd8);
		return (b < mn) ? mn : b;
	endfunction

endpackage

// ===== hdl/pps_if.sv =====
`timescale 1ns / 1ps

interface pps_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [15:0] entry_index;
	logic [15:0] entry_value;

	modport source(output valid, op, entry_index, entry_value, input ready);
	modport sink(input valid, op, entry_index, entry_value, output ready);
endinterface

interface pps_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] read_value;
	logic        out_of_range;
	logic [1:0]  form;
	logic [4:0]  width_in_use;
	logic [8:0]  palette_count;

	modport source(output valid, read_value, out_of_range, form, width_in_use,
		palette_count, input ready);
	modport sink(input valid, read_value, out_of_range, form, width_in_use,
		palette_count, output ready);
endinterface

// ===== hdl/pps_ram.sv =====
`timescale 1ns / 1ps

module pps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/pps_div.sv =====
`timescale 1ns / 1ps

module pps_div (
	input  logic               clk,
	input  logic               arst_n,
	input  pps_pkg::div_req_t  req,
	output pps_pkg::div_rsp_t  rsp
);
	import pps_pkg::*;

	localparam int DCNT_W = $clog2(CAP_W + 1);

	logic [PER_W-1:0]  rem_q;
	logic [CAP_W-1:0]  quo_q;
	logic [PER_W-1:0]  div_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [PER_W:0]    part;
	logic              ge;
	logic [PER_W:0]    diff;

	// one quotient bit per cycle, restoring
	assign part = {rem_q, quo_q[CAP_W-1]};
	assign ge   = part >= {1'b0, div_q};
	assign diff = part - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(CAP_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[PER_W-1:0] : part[PER_W-1:0];
			quo_q <= {quo_q[CAP_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== hdl/paletted_packed_store.sv =====
`timescale 1ns / 1ps
// A uniform read, a clear, an out-of-range index or an unused op goes from idle straight to
// the done state; other reads and direct writes first run the 12-step index divider, and an
// indexed write first searches the palette slot by slot.
// A repack walks every entry and then every packed word.
// One item at a time: no new input is taken until the last result is in the output register.
// Reset (arst_n low) returns the store to the uniform form with fill value 0.
module paletted_packed_store (
	input  logic                           clk,
	input  logic                           arst_n,
	pps_in_if.sink                         in_ch,
	pps_out_if.source                      out_ch,
	input  logic                           cfg_we,
	input  logic [pps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import pps_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DIV_GO, S_DIV_WAIT, S_RD_ISSUE, S_RD_WORD, S_RD_PAL,
		S_RMW_ISSUE, S_RMW_WR, S_SRCH_ISSUE, S_SRCH_CMP, S_APPEND,
		S_A_RD, S_A_EXT, S_A_PAL, S_COMMIT, S_B_RD, S_B_ACC, S_B_WR, S_DONE
	} state_t;

	state_t state_q;

	logic [12:0]       cap_q;
	logic [ID_W-1:0]   fill_q;
	logic [4:0]        dw_q;
	logic [3:0]        minw_q;
	logic [3:0]        maxw_q;

	logic [1:0]        form_q;
	logic [4:0]        width_q;
	logic [CNT_W-1:0]  used_q;
	logic [ID_W-1:0]   pal0_q;

	logic [1:0]        op_q;
	logic [CAP_W-1:0]  idx_q;
	logic [ID_W-1:0]   val_q;
	logic              oor_q;
	logic [ID_W-1:0]   rv_q;
	logic [ID_W-1:0]   pack_val_q;
	logic              tgt_direct_q;
	logic [4:0]        tgt_w_q;
	logic [CNT_W-1:0]  srch_q;

	logic [ENT_W-1:0]  ent_q;
	logic [WORD_W:0]   word_q;
	logic [PER_W-1:0]  pos_q;
	logic [SHIFT_W-1:0] shift_q;
	logic [WORD_B-1:0] acc_q;

	logic              out_valid_q;
	logic [ID_W-1:0]   out_rv_q;
	logic              out_oor_q;
	logic [1:0]        out_form_q;
	logic [4:0]        out_width_q;
	logic [8:0]        out_pcount_q;

	div_req_t          div_req;
	div_rsp_t          div_rsp;

	logic              w_we;
	logic [WORD_W-1:0] w_waddr, w_raddr;
	logic [WORD_B-1:0] w_wdata, w_rdata;
	logic              p_we;
	logic [PAL_W-1:0]  p_waddr, p_raddr;
	logic [ID_W-1:0]   p_wdata, p_rdata;
	logic              s_we;
	logic [CAP_W-1:0]  s_waddr, s_raddr;
	logic [ID_W-1:0]   s_wdata, s_rdata;

	logic [12:0]       cap_now;
	logic [PER_W-1:0]  per_cur;
	logic [ID_W-1:0]   mask_cur;
	logic [WORD_B-1:0] mask64;
	logic [ID_W-1:0]   field_cur;
	logic              pos_last;
	logic              ent_oor;
	logic              a_need_pal;
	logic              zero_word;
	logic              in_xfer;
	logic              out_load;
	logic [ID_W-1:0]   srch_cand;
	logic [CNT_W-1:0]  srch_next;
	logic [CNT_W:0]    miss_count;
	logic [4:0]        miss_needed;

	assign cap_now   = (cap_q > 13'(CAPACITY)) ? 13'(CAPACITY) : cap_q;
	assign per_cur   = per_of(width_q);
	assign mask_cur  = mask_of(width_q);
	assign mask64    = WORD_B'(mask_cur) << shift_q[5:0];
	assign field_cur = ID_W'(w_rdata >> shift_q[5:0]) & mask_cur;
	assign pos_last  = (PER_W'(pos_q + 1'b1) == per_cur);
	assign ent_oor   = ent_q >= ENT_W'(cap_now);
	assign a_need_pal = (form_q == FORM_INDEXED) && tgt_direct_q &&
		(CNT_W'(field_cur) < used_q) && (field_cur != '0);
	assign zero_word = (state_q == S_B_RD) && (word_q < (WORD_W + 1)'(WORD_DEPTH)) &&
		(pos_q == '0) && ent_oor;
	assign in_xfer   = in_ch.valid && in_ch.ready;
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);
	assign srch_cand = (srch_q == '0) ? pal0_q : p_rdata;
	assign srch_next = srch_q + 1'b1;
	assign miss_count  = {1'b0, used_q} + 1'b1;
	assign miss_needed = index_width_for(miss_count, minw_q);

	pps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	pps_ram #(.WIDTH(WORD_B), .DEPTH(WORD_DEPTH)) u_words (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(w_raddr), .rdata(w_rdata)
	);

	pps_ram #(.WIDTH(ID_W), .DEPTH(PALETTE_DEPTH)) u_palette (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata)
	);

	pps_ram #(.WIDTH(ID_W), .DEPTH(CAPACITY)) u_scratch (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	always_comb begin
		div_req.start    = (state_q == S_DIV_GO);
		div_req.dividend = idx_q;
		div_req.divisor  = per_cur;

		w_raddr = word_q[WORD_W-1:0];
		w_waddr = word_q[WORD_W-1:0];
		w_we    = 1'b0;
		w_wdata = '0;
		case (state_q)
			S_RMW_WR: begin
				w_we    = 1'b1;
				w_wdata = (w_rdata & ~mask64) |
					((WORD_B'(pack_val_q & mask_cur)) << shift_q[5:0]);
			end
			S_B_WR: begin
				w_we    = 1'b1;
				w_wdata = acc_q;
			end
			S_B_RD: begin
				w_we    = zero_word;
				w_wdata = '0;
			end
			default: ;
		endcase

		p_raddr = '0;
		case (state_q)
			S_SRCH_ISSUE:     p_raddr = srch_q[PAL_W-1:0];
			S_RD_WORD,
			S_A_EXT:          p_raddr = field_cur[PAL_W-1:0];
			default:          ;
		endcase
		p_we    = (state_q == S_APPEND) || ((state_q == S_COMMIT) && !tgt_direct_q);
		p_waddr = used_q[PAL_W-1:0];
		p_wdata = val_q;

		s_raddr = ent_q[CAP_W-1:0];
		s_waddr = ent_q[CAP_W-1:0];
		s_we    = 1'b0;
		s_wdata = '0;
		case (state_q)
			S_A_RD: begin
				s_we    = !ent_oor && (form_q == FORM_UNIFORM);
				s_wdata = tgt_direct_q ? pal0_q : '0;
			end
			S_A_EXT: begin
				s_we = !a_need_pal;
				if ((form_q == FORM_INDEXED) && tgt_direct_q) begin
					s_wdata = (CNT_W'(field_cur) < used_q) ? pal0_q : '0;
				end else begin
					s_wdata = field_cur;
				end
			end
			S_A_PAL: begin
				s_we    = 1'b1;
				s_wdata = p_rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_q       <= 13'(CAPACITY);
			fill_q      <= '0;
			dw_q        <= 5'd15;
			minw_q      <= 4'd4;
			maxw_q      <= 4'd8;
			form_q      <= FORM_UNIFORM;
			width_q     <= '0;
			used_q      <= CNT_W'(1);
			pal0_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_CAPACITY: cap_q  <= cfg_wdata[12:0];
					CFG_FILL:     fill_q <= cfg_wdata;
					CFG_DIRECT_W: dw_q   <= cfg_wdata[4:0];
					CFG_MIN_W:    minw_q <= cfg_wdata[3:0];
					CFG_MAX_W:    maxw_q <= cfg_wdata[3:0];
					default:      ;
				endcase
			end

			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			if (out_load) out_valid_q <= 1'b1;

			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						op_q    <= in_ch.op;
						idx_q   <= in_ch.entry_index[CAP_W-1:0];
						val_q   <= in_ch.entry_value;
						oor_q   <= in_ch.entry_index >= 16'(cap_now);
						rv_q    <= '0;
						srch_q  <= '0;
						ent_q   <= '0;
						word_q  <= '0;
						pos_q   <= '0;
						shift_q <= '0;
						acc_q   <= '0;
						state_q <= S_DONE;
						if (in_ch.entry_index < 16'(cap_now)) begin
							if (in_ch.op == OP_READ) begin
								if (form_q == FORM_UNIFORM) rv_q <= pal0_q;
								else state_q <= S_DIV_GO;
							end else if (in_ch.op == OP_WRITE) begin
								if (form_q == FORM_UNIFORM) begin
									if (in_ch.entry_value != pal0_q) begin
										tgt_direct_q <= 1'b0;
										tgt_w_q      <= index_width_for(10'd2, minw_q);
										pack_val_q   <= ID_W'(used_q);
										state_q      <= S_A_RD;
									end
								end else if (form_q == FORM_INDEXED) begin
									state_q <= S_SRCH_ISSUE;
								end else begin
									pack_val_q <= in_ch.entry_value;
									state_q    <= S_DIV_GO;
								end
							end
						end
						if (in_ch.op == OP_CLEAR) begin
							form_q  <= FORM_UNIFORM;
							width_q <= '0;
							used_q  <= CNT_W'(1);
							pal0_q  <= fill_q;
						end
					end
				end

				S_DIV_GO: state_q <= S_DIV_WAIT;

				S_DIV_WAIT: begin
					if (div_rsp.done) begin
						word_q  <= (WORD_W + 1)'(div_rsp.quot);
						shift_q <= SHIFT_W'(div_rsp.rem * width_q);
						if (div_rsp.quot >= CAP_W'(WORD_DEPTH)) state_q <= S_DONE;
						else if (op_q == OP_READ) state_q <= S_RD_ISSUE;
						else state_q <= S_RMW_ISSUE;
					end
				end

				S_RD_ISSUE: state_q <= S_RD_WORD;

				S_RD_WORD: begin
					state_q <= S_DONE;
					if (form_q == FORM_DIRECT) begin
						rv_q <= field_cur;
					end else if (CNT_W'(field_cur) < used_q && field_cur < ID_W'(256)) begin
						if (field_cur == '0) rv_q <= pal0_q;
						else state_q <= S_RD_PAL;
					end
				end

				S_RD_PAL: begin
					rv_q    <= p_rdata;
					state_q <= S_DONE;
				end

				S_RMW_ISSUE: state_q <= S_RMW_WR;

				S_RMW_WR: state_q <= S_DONE;

				S_SRCH_ISSUE: state_q <= S_SRCH_CMP;

				S_SRCH_CMP: begin
					if (srch_cand == val_q) begin
						pack_val_q <= ID_W'(srch_q);
						state_q    <= S_DIV_GO;
					end else if (srch_next < used_q) begin
						srch_q  <= srch_next;
						state_q <= S_SRCH_ISSUE;
					end else if (miss_needed > clamp_w({1'b0, maxw_q}, 5'd8) ||
						miss_count > (CNT_W + 1)'(PALETTE_DEPTH)) begin
						tgt_direct_q <= 1'b1;
						tgt_w_q      <= clamp_w(dw_q, 5'd16);
						pack_val_q   <= val_q;
						state_q      <= S_A_RD;
					end else if (miss_needed > width_q) begin
						tgt_direct_q <= 1'b0;
						tgt_w_q      <= miss_needed;
						pack_val_q   <= ID_W'(used_q);
						state_q      <= S_A_RD;
					end else begin
						pack_val_q <= ID_W'(used_q);
						state_q    <= S_APPEND;
					end
				end

				S_APPEND: begin
					used_q  <= used_q + 1'b1;
					state_q <= S_DIV_GO;
				end

				// gather every entry in the old encoding into scratch
				S_A_RD: begin
					if (ent_oor) begin
						state_q <= S_COMMIT;
					end else if (form_q == FORM_UNIFORM) begin
						ent_q <= ent_q + 1'b1;
						if (pos_last) begin
							pos_q <= '0; shift_q <= '0; word_q <= word_q + 1'b1;
						end else begin
							pos_q <= pos_q + 1'b1; shift_q <= shift_q + SHIFT_W'(width_q);
						end
					end else begin
						state_q <= S_A_EXT;
					end
				end

				S_A_EXT, S_A_PAL: begin
					if (state_q == S_A_EXT && a_need_pal) begin
						state_q <= S_A_PAL;
					end else begin
						state_q <= S_A_RD;
						ent_q   <= ent_q + 1'b1;
						if (pos_last) begin
							pos_q <= '0; shift_q <= '0; word_q <= word_q + 1'b1;
						end else begin
							pos_q <= pos_q + 1'b1; shift_q <= shift_q + SHIFT_W'(width_q);
						end
					end
				end

				S_COMMIT: begin
					width_q <= tgt_w_q;
					if (tgt_direct_q) begin
						form_q <= FORM_DIRECT;
						used_q <= '0;
					end else begin
						form_q <= FORM_INDEXED;
						used_q <= used_q + 1'b1;
					end
					ent_q   <= '0;
					word_q  <= '0;
					pos_q   <= '0;
					shift_q <= '0;
					acc_q   <= '0;
					state_q <= S_B_RD;
				end

				// rebuild every word at the new width
				S_B_RD: begin
					if (word_q >= (WORD_W + 1)'(WORD_DEPTH)) begin
						state_q <= S_DIV_GO;
					end else if (zero_word) begin
						word_q <= word_q + 1'b1;
						ent_q  <= ent_q + ENT_W'(per_cur);
					end else if (ent_oor) begin
						ent_q <= ent_q + 1'b1;
						if (pos_last) state_q <= S_B_WR;
						else begin
							pos_q <= pos_q + 1'b1; shift_q <= shift_q + SHIFT_W'(width_q);
						end
					end else begin
						state_q <= S_B_ACC;
					end
				end

				S_B_ACC: begin
					acc_q <= acc_q | ((WORD_B'(s_rdata & mask_cur)) << shift_q[5:0]);
					ent_q <= ent_q + 1'b1;
					if (pos_last) state_q <= S_B_WR;
					else begin
						pos_q   <= pos_q + 1'b1;
						shift_q <= shift_q + SHIFT_W'(width_q);
						state_q <= S_B_RD;
					end
				end

				S_B_WR: begin
					acc_q   <= '0;
					word_q  <= word_q + 1'b1;
					pos_q   <= '0;
					shift_q <= '0;
					state_q <= S_B_RD;
				end

				S_DONE: begin
					if (out_load) begin
						out_rv_q     <= rv_q;
						out_oor_q    <= oor_q;
						out_form_q   <= form_q;
						out_width_q  <= width_q;
						out_pcount_q <= (form_q == FORM_DIRECT) ? '0 : used_q;
						state_q      <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ch.ready          = (state_q == S_IDLE);
	assign out_ch.valid         = out_valid_q;
	assign out_ch.read_value    = out_rv_q;
	assign out_ch.out_of_range  = out_oor_q;
	assign out_ch.form          = out_form_q;
	assign out_ch.width_in_use  = out_width_q;
	assign out_ch.palette_count = out_pcount_q;

	a_uniform_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(form_q == FORM_UNIFORM) |-> (width_q == '0 && used_q == CNT_W'(1)))
		else $error("uniform form with nonzero width or palette size");

	a_indexed_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(form_q == FORM_INDEXED) |-> (used_q >= CNT_W'(2) && width_q >= 5'd1 &&
		width_q <= 5'd8))
		else $error("indexed form with bad palette size or width");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV_WAIT))
		else $error("divider finished outside its wait state");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q != S_IDLE))
		else $error("input accepted without leaving idle");

endmodule

// ===== sim/pps_tb_if_note.sv =====
`timescale 1ns / 1ps

// Channel interfaces come from hdl/pps_if.sv; this unit only carries shared tb types.
package pps_tb_types;
	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] entry_index;
		logic [15:0] entry_value;
	} store_req_t;

	typedef struct packed {
		logic [15:0] read_value;
		logic        out_of_range;
		logic [1:0]  form;
		logic [4:0]  width_in_use;
		logic [8:0]  palette_count;
	} store_rsp_t;
endpackage

// ===== sim/tb_paletted_packed_store.sv =====
`timescale 1ns / 1ps

module tb_paletted_packed_store;
	import pps_pkg::*;
	import pps_tb_types::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	pps_in_if in_ch();
	pps_out_if out_ch();

	paletted_packed_store dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// shadow of the store
	bit [63:0] words_m[WORD_DEPTH];
	bit [15:0] pal_m[PALETTE_DEPTH];
	bit [15:0] scratch_m[CAPACITY];
	int unsigned form_m, width_m, used_m;
	int unsigned cap_r, fill_r, dw_r, minw_r, maxw_r;

	store_req_t stim_q[$];
	store_rsp_t expected_answers[$];
	store_req_t cur_req;
	int in_gap, out_gap, mismatches;
	bit calm, failed;

	function automatic int unsigned clampw(int unsigned v, int unsigned lo, int unsigned hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic int unsigned cap_eff();
		return (cap_r > CAPACITY) ? CAPACITY : cap_r;
	endfunction

	function automatic int unsigned unpack(int unsigned idx, int unsigned w);
		int unsigned per, wd, sh;
		if (w == 0 || w > 16) return 0;
		per = 64 / w;
		wd = idx / per;
		if (wd >= WORD_DEPTH) return 0;
		sh = (idx % per) * w;
		return int'((words_m[wd] >> sh) & ((64'd1 << w) - 1));
	endfunction

	function automatic void pack(int unsigned idx, int unsigned w, int unsigned v);
		int unsigned per, wd, sh;
		bit [63:0] m;
		if (w == 0 || w > 16) return;
		per = 64 / w;
		wd = idx / per;
		if (wd >= WORD_DEPTH) return;
		sh = (idx % per) * w;
		m = ((64'd1 << w) - 1) << sh;
		words_m[wd] = (words_m[wd] & ~m) | ((64'(v) << sh) & m);
	endfunction

	function automatic int unsigned lookup(int unsigned idx);
		int unsigned s;
		if (form_m == FORM_UNIFORM) return pal_m[0];
		if (form_m == FORM_INDEXED) begin
			s = unpack(idx, width_m);
			return (s < used_m && s < PALETTE_DEPTH) ? pal_m[s] : 0;
		end
		return unpack(idx, width_m);
	endfunction

	function automatic int unsigned index_bits(int unsigned size);
		int unsigned b, mn;
		b = 0;
		mn = clampw(minw_r, 1, 8);
		while (b < 16 && (1 << b) < size) b++;
		return (b < mn) ? mn : b;
	endfunction

	function automatic int slot_of(int unsigned v);
		for (int unsigned i = 0; i < used_m && i < PALETTE_DEPTH; i++)
			if (pal_m[i] == v) return int'(i);
		return -1;
	endfunction

	function automatic void reencode(int unsigned w, bit to_direct, int unsigned v);
		int unsigned c;
		int s;
		c = cap_eff();
		for (int unsigned i = 0; i < c; i++) scratch_m[i] = 16'(lookup(i));
		if (to_direct) begin
			form_m = FORM_DIRECT;
			used_m = 0;
		end else begin
			pal_m[used_m] = 16'(v);
			used_m++;
			form_m = FORM_INDEXED;
		end
		width_m = w;
		foreach (words_m[i]) words_m[i] = '0;
		for (int unsigned i = 0; i < c; i++) begin
			if (to_direct) pack(i, w, scratch_m[i]);
			else begin
				s = slot_of(scratch_m[i]);
				pack(i, w, (s < 0) ? 0 : s);
			end
		end
	endfunction

	function automatic void store_write(int unsigned idx, int unsigned v);
		int unsigned cnt, need;
		int s;
		if (form_m == FORM_UNIFORM) begin
			if (pal_m[0] == v) return;
			used_m = 1;
			reencode(index_bits(2), 0, v);
			pack(idx, width_m, 1);
			return;
		end
		if (form_m == FORM_INDEXED) begin
			s = slot_of(v);
			if (s >= 0) begin
				pack(idx, width_m, s);
				return;
			end
			cnt = used_m + 1;
			need = index_bits(cnt);
			if (need > clampw(maxw_r, 1, 8) || cnt > PALETTE_DEPTH) begin
				reencode(clampw(dw_r, 1, 16), 1, 0);
				pack(idx, width_m, v);
				return;
			end
			if (need > width_m) reencode(need, 0, v);
			else begin
				pal_m[used_m] = 16'(v);
				used_m++;
			end
			pack(idx, width_m, used_m - 1);
			return;
		end
		pack(idx, width_m, v);
	endfunction

	function automatic void clear_shadow();
		form_m = FORM_UNIFORM;
		width_m = 0;
		used_m = 1;
		pal_m[0] = fill_r[15:0];
	endfunction

	function automatic store_rsp_t store_step(store_req_t r);
		store_rsp_t a;
		bit oor;
		oor = r.entry_index >= cap_eff();
		a.read_value = '0;
		if (r.op == OP_READ) begin
			if (!oor) a.read_value = 16'(lookup(r.entry_index));
		end else if (r.op == OP_WRITE) begin
			if (!oor) store_write(r.entry_index, r.entry_value);
		end else if (r.op == OP_CLEAR) clear_shadow();
		a.out_of_range = oor;
		a.form = form_m[1:0];
		a.width_in_use = width_m[4:0];
		a.palette_count = (form_m == FORM_DIRECT) ? 9'd0 : used_m[8:0];
		return a;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 0;
			in_ch.op <= OP_READ;
			in_ch.entry_index <= '0;
			in_ch.entry_value <= '0;
			in_gap = 0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				expected_answers.insert(expected_answers.size(), store_step(cur_req));
			if (!(in_ch.valid && !in_ch.ready)) begin
				if (in_gap > 0) begin
					in_gap--;
					in_ch.valid <= 0;
				end else if (stim_q.size() > 0) begin
					cur_req = stim_q.pop_front();
					in_ch.valid <= 1;
					in_ch.op <= cur_req.op;
					in_ch.entry_index <= cur_req.entry_index;
					in_ch.entry_value <= cur_req.entry_value;
					if (!calm && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 6);
				end else begin
					in_ch.valid <= 0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 0;
			out_gap = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_answers.size() == 0) begin
					failed = 1;
					mismatches++;
					if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
				end else begin
					store_rsp_t e;
					e = expected_answers.pop_front();
					if (out_ch.read_value !== e.read_value || out_ch.out_of_range !== e.out_of_range
						|| out_ch.form !== e.form || out_ch.width_in_use !== e.width_in_use
						|| out_ch.palette_count !== e.palette_count) begin
						failed = 1;
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch at %0t: exp val=%h oor=%b form=%0d w=%0d pal=%0d, got val=%h oor=%b form=%0d w=%0d pal=%0d",
								$realtime, e.read_value, e.out_of_range, e.form, e.width_in_use,
								e.palette_count, out_ch.read_value, out_ch.out_of_range,
								out_ch.form, out_ch.width_in_use, out_ch.palette_count);
					end
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ch.ready <= 0;
			end else begin
				out_ch.ready <= 1;
				if (!calm && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 6);
			end
		end
	end

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned data);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= data[15:0];
		case (idx)
			CFG_CAPACITY: cap_r = data & 16'h1FFF;
			CFG_FILL:     fill_r = data & 16'hFFFF;
			CFG_DIRECT_W: dw_r = data & 16'h1F;
			CFG_MIN_W:    minw_r = data & 16'hF;
			CFG_MAX_W:    maxw_r = data & 16'hF;
			default: ;
		endcase
	endtask

	task automatic end_cfg();
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic push_req(logic [1:0] op, int unsigned idx, int unsigned v);
		store_req_t r;
		r.op = op;
		r.entry_index = idx[15:0];
		r.entry_value = v[15:0];
		stim_q.insert(stim_q.size(), r);
	endtask

	// hold until every transfer has been answered
	task automatic drain();
		while (stim_q.size() > 0 || in_ch.valid || expected_answers.size() > 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic random_phase(int n);
		bit [15:0] ids[300];
		int unsigned pool_n, c, k;
		if ($urandom_range(0, 9) == 0) set_reg(CFG_CAPACITY, $urandom_range(1200, 4096));
		else if ($urandom_range(0, 4) == 0) set_reg(CFG_CAPACITY, $urandom_range(300, 1200));
		else set_reg(CFG_CAPACITY, $urandom_range(1, 300));
		set_reg(CFG_FILL, $urandom_range(0, 65535));
		set_reg(CFG_DIRECT_W, $urandom_range(0, 31));
		set_reg(CFG_MIN_W, $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom_range(1, 5));
		set_reg(CFG_MAX_W, $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom_range(4, 8));
		end_cfg();
		push_req(OP_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 65535));
		pool_n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 40);
		foreach (ids[i]) ids[i] = $urandom_range(0, 65535);
		c = cap_eff();
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			push_req(k < 45 ? OP_WRITE : (k < 90 ? OP_READ : (k < 93 ? OP_CLEAR : OP_NONE)),
				$urandom_range(0, 4) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, c + 1),
				$urandom_range(0, 9) == 0 ? $urandom_range(0, 65535) : ids[$urandom_range(0, pool_n - 1)]);
		end
		drain();
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_ch.valid = 0;
		in_ch.op = OP_READ;
		in_ch.entry_index = '0;
		in_ch.entry_value = '0;
		out_ch.ready = 0;
		mismatches = 0;
		failed = 0;
		calm = 0;
		cap_r = 4096; fill_r = 0; dw_r = 15; minw_r = 4; maxw_r = 8;
		foreach (words_m[i]) words_m[i] = '0;
		foreach (pal_m[i]) pal_m[i] = '0;
		clear_shadow();
		repeat (5) @(posedge clk);
		arst_n <= 1;
		repeat (3) @(posedge clk);

		// reset settings, full capacity
		push_req(OP_READ, 0, 0);
		push_req(OP_WRITE, 0, 0);
		push_req(OP_READ, 65535, 65535);
		push_req(OP_WRITE, 4095, 65535);
		push_req(OP_READ, 4095, 0);
		push_req(OP_READ, 0, 0);
		push_req(OP_WRITE, 4096, 1234);
		push_req(OP_NONE, 7, 99);
		push_req(OP_CLEAR, 0, 0);
		push_req(OP_READ, 4095, 0);
		drain();

		// oversized capacity acts as full, then zero capacity
		set_reg(CFG_CAPACITY, 8191);
		set_reg(CFG_FILL, 65535);
		end_cfg();
		push_req(OP_CLEAR, 0, 0);
		push_req(OP_READ, 4095, 0);
		push_req(OP_READ, 4096, 0);
		drain();
		set_reg(CFG_CAPACITY, 0);
		end_cfg();
		push_req(OP_READ, 0, 0);
		push_req(OP_WRITE, 0, 5);
		drain();

		// minimum above maximum, out-of-range widths
		set_reg(CFG_CAPACITY, 20);
		set_reg(CFG_DIRECT_W, 0);
		set_reg(CFG_MIN_W, 15);
		set_reg(CFG_MAX_W, 0);
		end_cfg();
		push_req(OP_WRITE, 3, 100);
		push_req(OP_WRITE, 19, 101);
		push_req(OP_READ, 3, 0);
		push_req(OP_READ, 19, 0);
		push_req(OP_READ, 20, 0);
		drain();

		// fill the palette until it overflows to direct form
		set_reg(CFG_CAPACITY, 300);
		set_reg(CFG_FILL, 0);
		set_reg(CFG_DIRECT_W, 31);
		set_reg(CFG_MIN_W, 0);
		set_reg(CFG_MAX_W, 15);
		end_cfg();
		push_req(OP_CLEAR, 0, 0);
		for (int i = 1; i <= 258; i++) push_req(OP_WRITE, i, 16'hFFFF - i);
		push_req(OP_READ, 5, 0);
		push_req(OP_READ, 258, 0);
		drain();

		for (int p = 0; p < 8; p++) begin
			if (p == 7) calm = 1;
			random_phase(90);
		end

		if (!failed) $display("[paletted_packed_store] OK");
		else $display("[paletted_packed_store] ERROR");
		$finish;
	end

	initial begin
		#1s;
		$display("[paletted_packed_store] ERROR");
		$finish;
	end
endmodule
